// File: sv/fsg_pkg.sv
// Shared types and constants for the falling sand grid stepper.
// Used by the channel interfaces, the top level and its checker.
package fsg_pkg;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 8;
    localparam int CELL_W     = 8;
    localparam int DIM_W      = 9;
    localparam int SEED_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [CELL_W-1:0]  t_cell;

    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;
    localparam t_cmd CMD_STEP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd2;

    localparam t_cell CELL_EMPTY = 8'd0;
    localparam t_cell CELL_SAND  = 8'd1;

    localparam logic [SEED_W-1:0] LFSR_MASK  = 16'hB400;
    localparam logic [SEED_W-1:0] RESET_SEED = 16'd1;
    localparam logic [DIM_W-1:0]  RESET_DIM  = 9'd256;

endpackage

// File: sv/fsg_in_if.sv
// Command channel of the falling sand grid stepper.
// Depends on fsg_pkg for the payload types.
interface fsg_in_if;
    import fsg_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   command;
    t_coord cell_x;
    t_coord cell_y;
    t_cell  cell_value;

    modport source (output valid, output command, output cell_x, output cell_y,
                    output cell_value, input ready);
    modport sink (input valid, input command, input cell_x, input cell_y,
                  input cell_value, output ready);
endinterface

// File: sv/fsg_out_if.sv
// Result channel of the falling sand grid stepper.
// Depends on fsg_pkg for the payload types.
interface fsg_out_if;
    import fsg_pkg::*;

    logic  valid;
    logic  ready;
    t_cell read_value;
    logic  any_moved;

    modport source (output valid, output read_value, output any_moved, input ready);
    modport sink (input valid, input read_value, input any_moved, output ready);
endinterface

// File: sv/falling_sand_grid_step.sv
// Falling sand grid stepper: a byte grid in one single-port memory, walked by a
// small sequencer around one shared address adder. Depends on fsg_pkg, fsg_in_if
// and fsg_out_if.
//
// One command word gives one result word. After reset the block runs a clearing
// pass over all MAX_WIDTH*MAX_HEIGHT cells (65536 at the defaults) before it
// takes a command; a clear command runs the same pass. A write passes through
// the command and finish states, a read through the command, read-data and
// finish states. A step visits the (height-1)*width active cells above the
// bottom row: a cell that is not sand is read and checked; for sand the cell
// below is checked and, if empty, the grain is moved straight down; else both
// diagonal cells are checked and the grain slides to a free one or stays. The
// pace is set by the single memory port, which serves one read or one write per
// cycle. A finished result waits in an output register, and the next command
// is accepted while it waits.
module falling_sand_grid_step #(
    parameter int MAX_WIDTH  = fsg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fsg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fsg_in_if.sink                          i_in,
    fsg_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [fsg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import fsg_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int EH    = $clog2(MAX_HEIGHT + 1);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_CMD      = 4'd2;
    localparam logic [3:0] S_RDATA    = 4'd3;
    localparam logic [3:0] S_RD_HERE  = 4'd4;
    localparam logic [3:0] S_CK_HERE  = 4'd5;
    localparam logic [3:0] S_CK_BELOW = 4'd6;
    localparam logic [3:0] S_CK_LEFT  = 4'd7;
    localparam logic [3:0] S_CK_RIGHT = 4'd8;
    localparam logic [3:0] S_WR_DST   = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    localparam logic [1:0] DX_ZERO  = 2'd0;
    localparam logic [1:0] DX_LEFT  = 2'd1;
    localparam logic [1:0] DX_RIGHT = 2'd2;

    logic [3:0]        r_state;
    logic [DIM_W-1:0]  r_grid_width;
    logic [DIM_W-1:0]  r_grid_height;
    logic [SEED_W-1:0] r_seed;
    logic [SEED_W-1:0] r_lfsr;

    t_cmd   r_cmd;
    t_coord r_x;
    t_coord r_y;
    t_cell  r_val;
    logic   r_inside;

    logic [AW-1:0] r_clr;
    logic          r_clr_cmd;
    logic [XW-1:0] r_sx;
    logic [YW-1:0] r_sy;
    logic [AW-1:0] r_row_base;
    logic          r_left_free;
    logic [1:0]    r_dx;
    logic          r_moved;

    t_cell r_res_rv;
    logic  r_res_mv;
    logic  r_out_valid;
    t_cell r_out_rv;
    logic  r_out_mv;

    t_cell r_grid [DEPTH];
    t_cell r_rdata;

    logic [EW-1:0]     eff_w;
    logic [EH-1:0]     eff_h;
    logic [SEED_W-1:0] lfsr_next;
    logic              x_has_left;
    logic              x_has_right;
    logic              right_free;
    logic              do_move;
    logic [1:0]        move_dx;
    logic              do_adv;
    logic [3:0]        adv_state;
    logic              au_below;
    logic [1:0]        au_dx;
    logic [AW:0]       au_sum;
    logic [AW-1:0]     au_addr;
    logic [AW-1:0]     cmd_addr;
    logic              mem_we;
    t_cell             mem_wdata;
    logic [AW-1:0]     mem_addr;
    logic              in_inside;

    always_comb begin
        int w;
        int h;
        w = 32'(r_grid_width);
        h = 32'(r_grid_height);
        if (w == 0) begin
            w = 1;
        end else if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        if (h == 0) begin
            h = 1;
        end else if (h > MAX_HEIGHT) begin
            h = MAX_HEIGHT;
        end
        eff_w = EW'(w);
        eff_h = EH'(h);
    end

    assign in_inside = (32'(i_in.cell_x) < 32'(eff_w)) && (32'(i_in.cell_y) < 32'(eff_h));
    assign cmd_addr  = AW'(32'(r_y) * MAX_WIDTH + 32'(r_x));

    assign lfsr_next   = {1'b0, r_lfsr[SEED_W-1:1]} ^ (r_lfsr[0] ? LFSR_MASK : '0);
    assign x_has_left  = (r_sx != '0);
    assign x_has_right = (32'(r_sx) + 32'd1) < 32'(eff_w);
    assign right_free  = x_has_right && (r_rdata == CELL_EMPTY);
    assign do_move     = r_left_free || right_free;
    assign adv_state   = (!x_has_right && (r_sy == '0)) ? S_FIN : S_RD_HERE;

    always_comb begin
        if (r_left_free && right_free) begin
            move_dx = lfsr_next[0] ? DX_LEFT : DX_RIGHT;
        end else if (r_left_free) begin
            move_dx = DX_LEFT;
        end else if (right_free) begin
            move_dx = DX_RIGHT;
        end else begin
            move_dx = DX_ZERO;
        end
    end

    // Shared address adder: row base, or the row below, plus column plus offset.
    always_comb begin
        logic [AW:0] base;
        logic [AW:0] offs;
        base = {1'b0, r_row_base};
        if (au_below) begin
            base = base + (AW+1)'(MAX_WIDTH);
        end
        unique case (au_dx)
            DX_LEFT:  offs = '1;
            DX_RIGHT: offs = (AW+1)'(1);
            default:  offs = '0;
        endcase
        au_sum = base + (AW+1)'(r_sx) + offs;
    end
    assign au_addr = au_sum[AW-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = CELL_EMPTY;
        au_below  = 1'b0;
        au_dx     = DX_ZERO;
        do_adv    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_CMD: begin
                mem_we    = (r_cmd == CMD_WRITE) && r_inside;
                mem_wdata = r_val;
            end
            S_CK_HERE: begin
                au_below = 1'b1;
                do_adv   = (r_rdata != CELL_SAND);
            end
            S_CK_BELOW: begin
                if (r_rdata == CELL_EMPTY) begin
                    mem_we = 1'b1;
                end else begin
                    au_below = 1'b1;
                    au_dx    = x_has_left ? DX_LEFT : DX_ZERO;
                end
            end
            S_CK_LEFT: begin
                au_below = 1'b1;
                au_dx    = x_has_right ? DX_RIGHT : DX_ZERO;
            end
            S_CK_RIGHT: begin
                mem_we = do_move;
                do_adv = !do_move;
            end
            S_WR_DST: begin
                au_below  = 1'b1;
                au_dx     = r_dx;
                mem_we    = 1'b1;
                mem_wdata = CELL_SAND;
                do_adv    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign mem_addr = (r_state == S_CLEAR) ? r_clr : (r_state == S_CMD) ? cmd_addr : au_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_grid[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_clr_cmd     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_moved       <= 1'b0;
            r_grid_width  <= RESET_DIM;
            r_grid_height <= RESET_DIM;
            r_seed        <= RESET_SEED;
            r_lfsr        <= RESET_SEED;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[DIM_W-1:0];
                    CFG_RANDOM_SEED: r_seed        <= i_cfg_data[SEED_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && o_out.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= r_clr_cmd ? S_FIN : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd    <= i_in.command;
                        r_x      <= i_in.cell_x;
                        r_y      <= i_in.cell_y;
                        r_val    <= i_in.cell_value;
                        r_inside <= in_inside;
                        r_state  <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_res_rv <= CELL_EMPTY;
                    r_res_mv <= 1'b0;
                    unique case (r_cmd)
                        CMD_CLEAR: begin
                            r_lfsr    <= (r_seed == '0) ? RESET_SEED : r_seed;
                            r_clr     <= '0;
                            r_clr_cmd <= 1'b1;
                            r_state   <= S_CLEAR;
                        end
                        CMD_WRITE: begin
                            r_state <= S_FIN;
                        end
                        CMD_READ: begin
                            r_state <= S_RDATA;
                        end
                        default: begin
                            r_moved <= 1'b0;
                            r_sx    <= '0;
                            if (32'(eff_h) < 2) begin
                                r_state <= S_FIN;
                            end else begin
                                r_sy       <= YW'(32'(eff_h) - 2);
                                r_row_base <= AW'((32'(eff_h) - 2) * MAX_WIDTH);
                                r_state    <= S_RD_HERE;
                            end
                        end
                    endcase
                end
                S_RDATA: begin
                    r_res_rv <= r_inside ? r_rdata : CELL_EMPTY;
                    r_state  <= S_FIN;
                end
                S_RD_HERE: begin
                    r_state <= S_CK_HERE;
                end
                S_CK_HERE: begin
                    r_state <= do_adv ? adv_state : S_CK_BELOW;
                end
                S_CK_BELOW: begin
                    if (r_rdata == CELL_EMPTY) begin
                        r_dx    <= DX_ZERO;
                        r_moved <= 1'b1;
                        r_state <= S_WR_DST;
                    end else begin
                        r_state <= S_CK_LEFT;
                    end
                end
                S_CK_LEFT: begin
                    r_left_free <= x_has_left && (r_rdata == CELL_EMPTY);
                    r_state     <= S_CK_RIGHT;
                end
                S_CK_RIGHT: begin
                    if (r_left_free && right_free) begin
                        r_lfsr <= lfsr_next;
                    end
                    r_dx    <= move_dx;
                    r_moved <= r_moved | do_move;
                    r_state <= do_adv ? adv_state : S_WR_DST;
                end
                S_WR_DST: begin
                    r_state <= adv_state;
                end
                S_FIN: begin
                    r_clr_cmd <= 1'b0;
                    if (!r_out_valid || o_out.ready) begin
                        r_out_rv    <= r_res_rv;
                        r_out_mv    <= r_res_mv;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (do_adv) begin
                if (x_has_right) begin
                    r_sx <= r_sx + XW'(1);
                end else if (r_sy == '0) begin
                    r_res_mv <= r_moved;
                end else begin
                    r_sx       <= '0;
                    r_sy       <= r_sy - YW'(1);
                    r_row_base <= r_row_base - AW'(MAX_WIDTH);
                end
            end
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_rv;
    assign o_out.any_moved  = r_out_mv;

endmodule

// File: sv/fsg_checker.sv
// Port-level checks for the falling sand grid stepper, bound to the top level.
// Depends on fsg_pkg for the payload types.
module fsg_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input fsg_pkg::t_cell i_read_value,
    input logic          i_any_moved
);
    import fsg_pkg::*;

    // The block works on one command at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while another is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_value)
                                        && $stable(i_any_moved))
        else $error("stalled result word changed");

    // Only a read gives a value and only a step reports movement.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_any_moved && (i_read_value != CELL_EMPTY)))
        else $error("result word carries both a read value and movement");

    // After reset the clearing pass runs before any command is taken.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("block not quiet after reset");

endmodule

bind falling_sand_grid_step fsg_checker u_fsg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_read_value (o_out.read_value),
    .i_any_moved  (o_out.any_moved)
);

// File: dv/falling_sand_grid_step_checker.sv
`timescale 1ns / 100ps
// Result checker for the falling sand grid stepper: a cell-level model of the grid
// fed from the command channel and the register port, compared against result words.
// Depends on fsg_pkg, fsg_in_if and fsg_out_if.
module falling_sand_grid_step_checker
    import fsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fsg_in_if                     cmd_ch,
    fsg_out_if                    res_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;

    typedef struct packed {
        t_cell read_value;
        logic  any_moved;
    } t_result;

    t_result            result_q[$];
    t_cell              cells [0:MAX_W*MAX_H-1];
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [SEED_W-1:0]  seed_reg;
    logic [SEED_W-1:0]  coin_state;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_error(input string msg);
        $display("[%0t] grid check: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic int active_dim(logic [DIM_W-1:0] r, int lim);
        if (r == 0) return 1;
        if (r > lim) return lim;
        return int'(r);
    endfunction

    function automatic void wipe_grid();
        foreach (cells[i]) cells[i] = CELL_EMPTY;
        coin_state = (seed_reg == 0) ? 16'd1 : seed_reg;
    endfunction

    function automatic logic flip_coin();
        logic out_bit;
        out_bit    = coin_state[0];
        coin_state = coin_state >> 1;
        if (out_bit) coin_state = coin_state ^ LFSR_MASK;
        return coin_state[0];
    endfunction

    function automatic logic settle_grain(int x, int y, int w);
        int   here;
        int   below;
        int   tx;
        logic left_free;
        logic right_free;
        here = y * MAX_W + x;
        if (cells[here] != CELL_SAND) return 1'b0;
        below = here + MAX_W;
        if (cells[below] == CELL_EMPTY) begin
            cells[here]  = CELL_EMPTY;
            cells[below] = CELL_SAND;
            return 1'b1;
        end
        left_free  = (x > 0) && (cells[below-1] == CELL_EMPTY);
        right_free = (x + 1 < w) && (cells[below+1] == CELL_EMPTY);
        if (left_free && right_free) begin
            tx = flip_coin() ? x - 1 : x + 1;
        end else if (left_free) begin
            tx = x - 1;
        end else if (right_free) begin
            tx = x + 1;
        end else begin
            return 1'b0;
        end
        cells[here] = CELL_EMPTY;
        cells[(y + 1) * MAX_W + tx] = CELL_SAND;
        return 1'b1;
    endfunction

    function automatic logic sand_pass();
        int   w;
        int   h;
        logic moved;
        w     = active_dim(width_reg, MAX_W);
        h     = active_dim(height_reg, MAX_H);
        moved = 1'b0;
        for (int y = h - 2; y >= 0; y--) begin
            for (int x = 0; x < w; x++) begin
                if (settle_grain(x, y, w)) moved = 1'b1;
            end
        end
        return moved;
    endfunction

    function automatic t_result predict(t_cmd cmd, t_coord x, t_coord y, t_cell v);
        t_result r;
        logic    in_area;
        r = '0;
        in_area = (x < active_dim(width_reg, MAX_W)) && (y < active_dim(height_reg, MAX_H));
        case (cmd)
            CMD_CLEAR: wipe_grid();
            CMD_WRITE: if (in_area) cells[y * MAX_W + x] = v;
            CMD_READ:  if (in_area) r.read_value = cells[y * MAX_W + x];
            default:   r.any_moved = sand_pass();
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            width_reg  = RESET_DIM;
            height_reg = RESET_DIM;
            seed_reg   = RESET_SEED;
            wipe_grid();
            result_q.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (result_q.size() == 0) begin
                    report_error("result word with nothing expected");
                end else begin
                    want = result_q.pop_front();
                    if (res_ch.read_value !== want.read_value)
                        report_error($sformatf("read_value %0h, expected %0h",
                                               res_ch.read_value, want.read_value));
                    if (res_ch.any_moved !== want.any_moved)
                        report_error($sformatf("any_moved %0b, expected %0b",
                                               res_ch.any_moved, want.any_moved));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:  width_reg  = i_cfg_data[DIM_W-1:0];
                    CFG_GRID_HEIGHT: height_reg = i_cfg_data[DIM_W-1:0];
                    CFG_RANDOM_SEED: seed_reg   = i_cfg_data[SEED_W-1:0];
                    default: ;
                endcase
            end
            if (cmd_ch.valid && cmd_ch.ready)
                result_q.push_back(predict(cmd_ch.command, cmd_ch.cell_x, cmd_ch.cell_y,
                                           cmd_ch.cell_value));
        end
        o_pending = result_q.size();
    end

endmodule

// File: dv/falling_sand_grid_step_tb.sv
`timescale 1ns / 100ps
// Top of the falling sand grid stepper testbench: clock, reset, command stimulus,
// register writes and result back-pressure. Depends on fsg_pkg, both channel
// interfaces, the block itself and falling_sand_grid_step_checker.
module falling_sand_grid_step_tb;
    import fsg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RUN_LIMIT_NS = 20_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  quiet;
    int                    fail_count;
    int                    pending;
    int                    cur_w;
    int                    cur_h;

    fsg_in_if  cmd_ch();
    fsg_out_if res_ch();

    falling_sand_grid_step uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (cmd_ch),
        .o_out       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    falling_sand_grid_step_checker grid_model_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd_ch       (cmd_ch),
        .res_ch       (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL falling_sand_grid_step");
        $finish;
    end

    function automatic int gap_len();
        int pick;
        if (quiet) return 0;
        pick = $urandom_range(0, 19);
        if (pick < 12) return 0;
        if (pick < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int pick;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            pick = $urandom_range(0, 19);
            if (!quiet && pick < 5) begin
                res_ch.ready <= 1'b0;
                repeat (pick == 0 ? $urandom_range(15, 60) : $urandom_range(1, 3))
                    @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    task automatic send_word(t_cmd c, t_coord x, t_coord y, t_cell v);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= c;
        cmd_ch.cell_x     <= x;
        cmd_ch.cell_y     <= y;
        cmd_ch.cell_value <= v;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes, reads and steps; writes are mostly sand dropped inside the active area,
    // with some obstacles, erasures and accesses outside it, so piles build up and slide between steps.
    task automatic random_word();
        int     pick;
        t_coord x;
        t_coord y;
        t_cell  v;
        pick = $urandom_range(0, 99);
        x = ($urandom_range(0, 6) == 0) ? t_coord'($urandom_range(0, 255))
                                        : t_coord'($urandom_range(0, cur_w - 1));
        y = ($urandom_range(0, 6) == 0) ? t_coord'($urandom_range(0, 255))
                                        : t_coord'($urandom_range(0, cur_h - 1));
        v = t_cell'($urandom_range(0, 255));
        if (pick < 45) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: v = CELL_SAND;
                7:                   v = CELL_EMPTY;
                default:             v = t_cell'($urandom_range(2, 255));
            endcase
            send_word(CMD_WRITE, x, y, v);
        end else if (pick < 70) begin
            send_word(CMD_READ, x, y, v);
        end else begin
            send_word(CMD_STEP, x, y, v);
        end
    endtask

    initial begin
        logic [SEED_W-1:0] seed;
        quiet             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.command    = CMD_CLEAR;
        cmd_ch.cell_x     = '0;
        cmd_ch.cell_y     = '0;
        cmd_ch.cell_value = '0;
        i_rst_n           = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Full default grid: edge columns, a straight fall, a forced slide and a coin toss.
        send_word(CMD_READ,  8'd255, 8'd255, 8'd0);
        send_word(CMD_WRITE, 8'd255, 8'd255, 8'hFF);
        send_word(CMD_WRITE, 8'd255, 8'd254, CELL_SAND);
        send_word(CMD_WRITE, 8'd0,   8'd254, CELL_SAND);
        send_word(CMD_WRITE, 8'd100, 8'd100, CELL_SAND);
        send_word(CMD_WRITE, 8'd50,  8'd253, CELL_SAND);
        send_word(CMD_WRITE, 8'd50,  8'd254, 8'h80);
        send_word(CMD_STEP,  8'd0,   8'd0,   8'd0);
        send_word(CMD_READ,  8'd254, 8'd255, 8'd0);
        send_word(CMD_READ,  8'd255, 8'd255, 8'd0);

        // A zero width acts as one column and an oversized height as the maximum.
        // The new seed must not take effect before the next clear.
        drain_results();
        write_reg(CFG_GRID_WIDTH, 16'd0);
        write_reg(CFG_GRID_HEIGHT, 16'h01FF);
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(CFG_RANDOM_SEED, 16'd0);
        send_word(CMD_WRITE, 8'd0,   8'd0,   CELL_SAND);
        send_word(CMD_WRITE, 8'd1,   8'd0,   CELL_SAND);
        send_word(CMD_READ,  8'd100, 8'd101, 8'd0);
        send_word(CMD_STEP,  8'd0,   8'd0,   8'd0);
        send_word(CMD_READ,  8'd0,   8'd1,   8'd0);

        // A single row never moves; hidden cells keep their contents.
        drain_results();
        write_reg(CFG_GRID_WIDTH, 16'h01FF);
        write_reg(CFG_GRID_HEIGHT, 16'd1);
        send_word(CMD_WRITE, 8'd3,   8'd0,   CELL_SAND);
        send_word(CMD_STEP,  8'd0,   8'd0,   8'd0);
        send_word(CMD_READ,  8'd100, 8'd0,   8'd0);
        drain_results();
        write_reg(CFG_GRID_HEIGHT, 16'd256);
        send_word(CMD_READ,  8'd100, 8'd101, 8'd0);
        send_word(CMD_CLEAR, 8'd0,   8'd0,   8'd0);
        send_word(CMD_READ,  8'd255, 8'd254, 8'd0);

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    cur_w = 8;
                    cur_h = 6;
                    seed  = 16'hFFFF;
                end
                1: begin
                    cur_w = 2;
                    cur_h = 10;
                    seed  = SEED_W'($urandom_range(1, 65535));
                end
                2: begin
                    cur_w = 256;
                    cur_h = 2;
                    seed  = SEED_W'($urandom_range(1, 65535));
                end
                default: begin
                    cur_w = $urandom_range(2, 24);
                    cur_h = $urandom_range(2, 24);
                    seed  = SEED_W'($urandom_range(1, 65535));
                end
            endcase
            drain_results();
            quiet = (p == 1) || ($urandom_range(0, 3) == 0);
            write_reg(CFG_GRID_WIDTH, 16'(cur_w));
            write_reg(CFG_GRID_HEIGHT, 16'(cur_h));
            write_reg(CFG_RANDOM_SEED, seed);
            send_word(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
            repeat (20) random_word();
        end

        drain_results();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS falling_sand_grid_step");
        end else begin
            $display("FAIL falling_sand_grid_step");
        end
        $finish;
    end

endmodule
